[sv/epr_pkg.sv]
package epr_pkg;

   // default configuration of the block
   localparam int ANGLE_BITS_DEFAULT     = 12;
   localparam int TRIG_FRAC_BITS_DEFAULT = 14;

   // fixed field widths
   localparam int COORD_W     = 32;
   localparam int DELTA_W     = COORD_W + 1;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // entries in the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   localparam real HALF_PI = 1.5707963267948966;

   // register indexes of the configuration port
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_ANGLE_X  = 3'd0,
      REG_ANGLE_Y  = 3'd1,
      REG_ANGLE_Z  = 3'd2,
      REG_CENTER_X = 3'd3,
      REG_CENTER_Y = 3'd4,
      REG_CENTER_Z = 3'd5
   } csr_index_type;

   // point minus center, exact
   typedef struct packed {
      logic signed [DELTA_W-1:0] dx;
      logic signed [DELTA_W-1:0] dy;
      logic signed [DELTA_W-1:0] dz;
   } delta_type;

   // rounded sine of idx / 2^qbits quarter turns, scaled by 2^frac
   function automatic int quarter_sin(int idx, int qbits, int frac);
      real ang;
      real v;
      ang = real'(idx) * HALF_PI * (2.0 ** (-qbits));
      v   = $sin(ang) * (2.0 ** frac) + 0.5;
      return $rtoi($floor(v));
   endfunction

endpackage

[sv/epr_if.sv]
// input channel: one point per item
interface epr_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [epr_pkg::COORD_W-1:0]   point_x;
   logic signed [epr_pkg::COORD_W-1:0]   point_y;
   logic signed [epr_pkg::COORD_W-1:0]   point_z;

   modport source (output valid, output point_x, output point_y, output point_z, input ready);
   modport sink   (input valid, input point_x, input point_y, input point_z, output ready);
endinterface

// result channel: one rotated point per item
interface epr_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [epr_pkg::COORD_W-1:0]   rotated_x;
   logic signed [epr_pkg::COORD_W-1:0]   rotated_y;
   logic signed [epr_pkg::COORD_W-1:0]   rotated_z;
   logic                                 clipped;

   modport source (output valid, output rotated_x, output rotated_y, output rotated_z,
                   output clipped, input ready);
   modport sink   (input valid, input rotated_x, input rotated_y, input rotated_z,
                   input clipped, output ready);
endinterface

[sv/euler_point_rotator_unit.sv]
// Rotates 3D points (signed Q16.16) about a programmed center by three
// binary angles. req_ch carries one point per item, rsp_ch one rotated,
// saturated point per item with a clipped flag; valid/ready on both.
// csr_we/csr_index/csr_data write angle_x/y/z (indexes 0..2) and
// center_x/y/z (3..5); other indexes are ignored.
// Throughput: one item per cycle while no rebuild runs and rsp_ch
// is not stalled. A req passes the front queue, then the product,
// row sum and clamp stages, before rsp valid rises.
// A write of an angle starts a matrix rebuild: 6 sine table
// reads and 14 products through one shared multiplier; req_ch.ready is
// low meanwhile. Center writes take effect at once.
// Reset gives the identity matrix, zero angles and centers, and empty
// channels. When rsp_ch stalls the pipeline holds; the front queue
// takes items until its 4 entries are full, then req_ch.ready drops.
module euler_point_rotator_unit #(
   parameter int ANGLE_BITS     = epr_pkg::ANGLE_BITS_DEFAULT,
   parameter int TRIG_FRAC_BITS = epr_pkg::TRIG_FRAC_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   epr_req_if.sink                                req_ch,
   epr_rsp_if.source                              rsp_ch,
   input  logic                                   csr_we,
   input  logic [epr_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [epr_pkg::CSR_DATA_W-1:0]         csr_data
);
   localparam int MW = TRIG_FRAC_BITS + 3;

   logic [ANGLE_BITS-1:0]                 angle_x_ff, angle_y_ff, angle_z_ff;
   logic signed [epr_pkg::COORD_W-1:0]    center_x_ff, center_y_ff, center_z_ff;
   logic                                  start_ff;
   logic                                  busy;
   logic [8:0][MW-1:0]                    matrix;
   logic                                  q_valid, q_ready;
   epr_pkg::delta_type                    q_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         angle_x_ff  <= '0;
         angle_y_ff  <= '0;
         angle_z_ff  <= '0;
         center_x_ff <= '0;
         center_y_ff <= '0;
         center_z_ff <= '0;
         start_ff    <= 1'b0;
      end else begin
         start_ff <= 1'b0;
         if (csr_we) begin
            unique case (epr_pkg::csr_index_type'(csr_index))
               epr_pkg::REG_ANGLE_X: begin
                  angle_x_ff <= csr_data[ANGLE_BITS-1:0];
                  start_ff   <= 1'b1;
               end
               epr_pkg::REG_ANGLE_Y: begin
                  angle_y_ff <= csr_data[ANGLE_BITS-1:0];
                  start_ff   <= 1'b1;
               end
               epr_pkg::REG_ANGLE_Z: begin
                  angle_z_ff <= csr_data[ANGLE_BITS-1:0];
                  start_ff   <= 1'b1;
               end
               epr_pkg::REG_CENTER_X: center_x_ff <= csr_data;
               epr_pkg::REG_CENTER_Y: center_y_ff <= csr_data;
               epr_pkg::REG_CENTER_Z: center_z_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // hold off input from the write onward until the rebuild ends
   logic hold;
   assign hold = busy || start_ff;

   epr_matrix_builder #(
      .ANGLE_BITS     (ANGLE_BITS),
      .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
   ) u_builder (
      .clock   (clock),
      .reset   (reset),
      .start   (start_ff),
      .angle_x (angle_x_ff),
      .angle_y (angle_y_ff),
      .angle_z (angle_z_ff),
      .busy    (busy),
      .matrix  (matrix)
   );

   epr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .hold     (hold),
      .center_x (center_x_ff),
      .center_y (center_y_ff),
      .center_z (center_z_ff),
      .req      (req_ch),
      .q_valid  (q_valid),
      .q_data   (q_data),
      .q_ready  (q_ready)
   );

   epr_back #(
      .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .matrix   (matrix),
      .center_x (center_x_ff),
      .center_y (center_y_ff),
      .center_z (center_z_ff),
      .q_valid  (q_valid),
      .q_data   (q_data),
      .q_ready  (q_ready),
      .rsp      (rsp_ch)
   );
endmodule

[sv/epr_matrix_builder.sv]
module epr_matrix_builder #(
   parameter int ANGLE_BITS     = epr_pkg::ANGLE_BITS_DEFAULT,
   parameter int TRIG_FRAC_BITS = epr_pkg::TRIG_FRAC_BITS_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   input  logic [ANGLE_BITS-1:0]                   angle_x,
   input  logic [ANGLE_BITS-1:0]                   angle_y,
   input  logic [ANGLE_BITS-1:0]                   angle_z,
   output logic                                    busy,
   output logic [8:0][TRIG_FRAC_BITS+2:0]          matrix
);
   localparam int QB    = ANGLE_BITS - 2;
   localparam int AW    = QB + 1;
   localparam int TW    = TRIG_FRAC_BITS + 2;
   localparam int MW    = TRIG_FRAC_BITS + 3;
   localparam int PW    = 2 * TW;
   localparam int ROM_N = 2 ** QB + 1;

   // sequencer: table reads, then products
   localparam logic [4:0] STEP_LAST  = 5'd20;

   logic [4:0]                cnt_ff, cnt_in;
   logic                      busy_ff, busy_in;
   logic [TW-1:0]             rom_word [ROM_N];
   logic [TW-1:0]             rom_q_ff;
   logic                      neg_ff;
   logic [ANGLE_BITS-1:0]     rd_angle;
   logic [1:0]                rd_quad;
   logic [QB-1:0]             rd_frac;
   logic [AW-1:0]             rd_addr;
   logic signed [TW-1:0]      trig_val;
   logic signed [TW-1:0]      sx_ff, cx_ff, sy_ff, cy_ff, sz_ff, cz_ff, t6_ff, t7_ff;
   logic signed [TW-1:0]      op_a, op_b;
   logic signed [PW-1:0]      prod, prod_rnd, prod_shr;
   logic signed [MW-1:0]      pm_m;
   logic [8:0][MW-1:0]        m_ff;

   // quarter-wave sine table, one extra entry for the full value
   for (genvar g = 0; g < ROM_N; g++) begin : g_rom
      assign rom_word[g] = TW'(epr_pkg::quarter_sin(g, QB, TRIG_FRAC_BITS));
   end

   // table address: cosine is sine a quarter turn on
   always_comb begin
      case (cnt_ff[2:1])
         2'd0:    rd_angle = angle_x;
         2'd1:    rd_angle = angle_y;
         default: rd_angle = angle_z;
      endcase
      rd_quad = rd_angle[ANGLE_BITS-1:ANGLE_BITS-2] + {1'b0, cnt_ff[0]};
      rd_frac = rd_angle[QB-1:0];
      rd_addr = rd_quad[0] ? (AW'(ROM_N - 1) - {1'b0, rd_frac}) : {1'b0, rd_frac};
   end

   always_ff @(posedge clock) begin
      rom_q_ff <= rom_word[rd_addr];
      neg_ff   <= rd_quad[1];
   end

   assign trig_val = neg_ff ? -$signed(rom_q_ff) : $signed(rom_q_ff);

   // operand selection per product step
   always_comb begin
      case (cnt_ff)
         5'd7:    begin op_a = sx_ff; op_b = sy_ff; end
         5'd8:    begin op_a = cx_ff; op_b = sy_ff; end
         5'd9:    begin op_a = cy_ff; op_b = cz_ff; end
         5'd10:   begin op_a = cx_ff; op_b = sz_ff; end
         5'd11:   begin op_a = t6_ff; op_b = cz_ff; end
         5'd12:   begin op_a = sx_ff; op_b = sz_ff; end
         5'd13:   begin op_a = t7_ff; op_b = cz_ff; end
         5'd14:   begin op_a = cy_ff; op_b = sz_ff; end
         5'd15:   begin op_a = cx_ff; op_b = cz_ff; end
         5'd16:   begin op_a = t6_ff; op_b = sz_ff; end
         5'd17:   begin op_a = sx_ff; op_b = cz_ff; end
         5'd18:   begin op_a = t7_ff; op_b = sz_ff; end
         5'd19:   begin op_a = sx_ff; op_b = cy_ff; end
         5'd20:   begin op_a = cx_ff; op_b = cy_ff; end
         default: begin op_a = '0;    op_b = '0;    end
      endcase
   end

   // product rounded half up back to the trig scale
   assign prod     = op_a * op_b;
   assign prod_rnd = prod + (PW'(1) <<< (TRIG_FRAC_BITS - 1));
   assign prod_shr = prod_rnd >>> TRIG_FRAC_BITS;
   assign pm_m     = MW'(prod_shr);

   // step control
   always_comb begin
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == STEP_LAST) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         for (int i = 0; i < 9; i++) begin
            m_ff[i] <= (i == 0 || i == 4 || i == 8) ? (MW'(1) << TRIG_FRAC_BITS) : '0;
         end
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         if (busy_ff && !start) begin
            case (cnt_ff)
               5'd1:  sx_ff <= trig_val;
               5'd2:  cx_ff <= trig_val;
               5'd3:  sy_ff <= trig_val;
               5'd4:  cy_ff <= trig_val;
               5'd5:  sz_ff <= trig_val;
               5'd6:  cz_ff <= trig_val;
               5'd7:  t6_ff <= TW'(pm_m);
               5'd8:  t7_ff <= TW'(pm_m);
               5'd9:  m_ff[0] <= pm_m;
               5'd10: m_ff[1] <= pm_m;
               5'd11: m_ff[1] <= m_ff[1] + pm_m;
               5'd12: m_ff[2] <= pm_m;
               5'd13: m_ff[2] <= m_ff[2] - pm_m;
               5'd14: m_ff[3] <= -pm_m;
               5'd15: m_ff[4] <= pm_m;
               5'd16: m_ff[4] <= m_ff[4] - pm_m;
               5'd17: m_ff[5] <= pm_m;
               5'd18: m_ff[5] <= m_ff[5] + pm_m;
               5'd19: m_ff[7] <= -pm_m;
               5'd20: begin
                  m_ff[8] <= pm_m;
                  m_ff[6] <= MW'(sy_ff);
               end
               default: ;
            endcase
         end
      end
   end

   assign busy   = busy_ff;
   assign matrix = m_ff;
endmodule

[sv/epr_front.sv]
module epr_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   hold,
   input  logic signed [epr_pkg::COORD_W-1:0]     center_x,
   input  logic signed [epr_pkg::COORD_W-1:0]     center_y,
   input  logic signed [epr_pkg::COORD_W-1:0]     center_z,
   epr_req_if.sink                                req,
   output logic                                   q_valid,
   output epr_pkg::delta_type                     q_data,
   input  logic                                   q_ready
);
   localparam int DEPTH = epr_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = PTR_W + 1;

   epr_pkg::delta_type  mem [DEPTH];
   epr_pkg::delta_type  delta;
   logic [PTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                push, pop;

   // subtract the center on the way in
   always_comb begin
      delta.dx = epr_pkg::DELTA_W'(req.point_x) - epr_pkg::DELTA_W'(center_x);
      delta.dy = epr_pkg::DELTA_W'(req.point_y) - epr_pkg::DELTA_W'(center_y);
      delta.dz = epr_pkg::DELTA_W'(req.point_z) - epr_pkg::DELTA_W'(center_z);
   end

   // no new items while the matrix is rebuilt
   assign req.ready = (count_ff != CNT_W'(DEPTH)) && !hold;
   assign push      = req.valid && req.ready;
   assign pop       = q_valid && q_ready;
   assign q_valid   = (count_ff != '0);
   assign q_data    = mem[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + CNT_W'(1);
      if (pop && !push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (push) mem[wr_ptr_ff] <= delta;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         count_ff <= count_in;
      end
   end
endmodule

[sv/epr_back.sv]
module epr_back #(
   parameter int TRIG_FRAC_BITS = epr_pkg::TRIG_FRAC_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [8:0][TRIG_FRAC_BITS+2:0]         matrix,
   input  logic signed [epr_pkg::COORD_W-1:0]     center_x,
   input  logic signed [epr_pkg::COORD_W-1:0]     center_y,
   input  logic signed [epr_pkg::COORD_W-1:0]     center_z,
   input  logic                                   q_valid,
   input  epr_pkg::delta_type                     q_data,
   output logic                                   q_ready,
   epr_rsp_if.source                              rsp
);
   localparam int CW  = epr_pkg::COORD_W;
   localparam int MW  = TRIG_FRAC_BITS + 3;
   localparam int PW  = MW + epr_pkg::DELTA_W;
   localparam int SW  = PW + 2;
   localparam int RW  = SW - TRIG_FRAC_BITS;
   localparam int TTW = RW + 1;
   localparam logic signed [TTW-1:0] MAX_V = TTW'(32'sh7fff_ffff);
   localparam logic signed [TTW-1:0] MIN_V = TTW'(32'sh8000_0000);

   logic                          en;
   logic                          v1_ff, v2_ff, v3_ff;
   logic signed [epr_pkg::DELTA_W-1:0] dv [3];
   logic signed [CW-1:0]          cv [3];
   logic signed [PW-1:0]          p_ff [9];
   logic signed [SW-1:0]          acc [3];
   logic signed [SW-1:0]          acc_rnd [3];
   logic signed [SW-1:0]          acc_shr [3];
   logic signed [RW-1:0]          r_ff [3];
   logic signed [TTW-1:0]         tot [3];
   logic signed [CW-1:0]          sat [3];
   logic [2:0]                    clip;
   logic signed [CW-1:0]          out_ff [3];
   logic                          clip_ff;

   // whole pipeline moves unless the output is stalled
   assign en      = !v3_ff || rsp.ready;
   assign q_ready = en;

   assign dv[0] = q_data.dx;
   assign dv[1] = q_data.dy;
   assign dv[2] = q_data.dz;
   assign cv[0] = center_x;
   assign cv[1] = center_y;
   assign cv[2] = center_z;

   // stage 1: nine products
   always_ff @(posedge clock) begin
      if (en) begin
         for (int row = 0; row < 3; row++) begin
            for (int col = 0; col < 3; col++) begin
               p_ff[3*row+col] <= PW'($signed(matrix[3*row+col])) * PW'(dv[col]);
            end
         end
      end
   end

   // stage 2: row sums, rounded half up
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc[i]     = SW'(p_ff[3*i]) + SW'(p_ff[3*i+1]) + SW'(p_ff[3*i+2]);
         acc_rnd[i] = acc[i] + (SW'(1) <<< (TRIG_FRAC_BITS - 1));
         acc_shr[i] = acc_rnd[i] >>> TRIG_FRAC_BITS;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) r_ff[i] <= RW'(acc_shr[i]);
      end
   end

   // stage 3: center back in, clamp to 32 bits
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         tot[i]  = TTW'(r_ff[i]) + TTW'(cv[i]);
         clip[i] = 1'b0;
         sat[i]  = CW'(tot[i]);
         if (tot[i] > MAX_V) begin
            sat[i]  = CW'(MAX_V);
            clip[i] = 1'b1;
         end else if (tot[i] < MIN_V) begin
            sat[i]  = CW'(MIN_V);
            clip[i] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) out_ff[i] <= sat[i];
         clip_ff <= |clip;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= q_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   assign rsp.valid     = v3_ff;
   assign rsp.rotated_x = out_ff[0];
   assign rsp.rotated_y = out_ff[1];
   assign rsp.rotated_z = out_ff[2];
   assign rsp.clipped   = clip_ff;
endmodule

[sv/epr_checker.sv]
module epr_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic signed [epr_pkg::COORD_W-1:0]    rotated_x,
   input logic signed [epr_pkg::COORD_W-1:0]    rotated_y,
   input logic signed [epr_pkg::COORD_W-1:0]    rotated_z,
   input logic                                  clipped,
   input logic                                  csr_we,
   input logic [epr_pkg::CSR_INDEX_W-1:0]       csr_index
);
   localparam logic signed [epr_pkg::COORD_W-1:0] MAX_V = 32'sh7fff_ffff;
   localparam logic signed [epr_pkg::COORD_W-1:0] MIN_V = 32'sh8000_0000;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rotated_x) && $stable(rotated_y)
         && $stable(rotated_z) && $stable(clipped))
      else $error("result changed while stalled");

   // an angle write blocks input for the rebuild
   a_rebuild_block: assert property (@(posedge clock) disable iff (reset)
      csr_we && (csr_index == epr_pkg::REG_ANGLE_X || csr_index == epr_pkg::REG_ANGLE_Y
         || csr_index == epr_pkg::REG_ANGLE_Z) |=> !req_ready)
      else $error("input taken during matrix rebuild");

   // clipped only with a coordinate at a rail
   a_clip_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && clipped |-> rotated_x == MAX_V || rotated_x == MIN_V
         || rotated_y == MAX_V || rotated_y == MIN_V
         || rotated_z == MAX_V || rotated_z == MIN_V)
      else $error("clipped without saturated coordinate");

   // reset empties the output
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");
endmodule

bind euler_point_rotator_unit epr_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rotated_x (rsp_ch.rotated_x),
   .rotated_y (rsp_ch.rotated_y),
   .rotated_z (rsp_ch.rotated_z),
   .clipped   (rsp_ch.clipped),
   .csr_we    (csr_we),
   .csr_index (csr_index)
);
